FILE: rtl/core/cross_morphology_filter_unit_defines.svh
// Assertion macros used by the cross morphology filter top level.
`ifndef CROSS_MORPHOLOGY_FILTER_UNIT_DEFINES_SVH
`define CROSS_MORPHOLOGY_FILTER_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define CMF_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication checked at every clock edge out of reset.
`define CMF_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/cmf_pkg.sv
// Types, constants and helper functions of the cross morphology filter.
package cmf_pkg;

	// Geometry limits
	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;
	localparam int DIM_W    = 11;
	localparam int CNT_W    = $clog2(MAX_COLS * MAX_ROWS + 1);
	localparam int SUM_W    = CNT_W + 1;

	// Reset geometry
	localparam logic [DIM_W-1:0] COLS_RST = DIM_W'(256);
	localparam logic [DIM_W-1:0] ROWS_RST = DIM_W'(256);
	localparam logic [CNT_W-1:0] NPIX_RST = CNT_W'(256 * 256);

	// Window store: must hold 2*cols+1 pixels of history; power of two keeps
	// the address a plain slice of the pixel count.
	localparam int WIN_DEPTH = 2 ** $clog2(2 * MAX_COLS + 1);
	localparam int WIN_AW    = $clog2(WIN_DEPTH);

	// Pixel levels
	localparam int PIX_W = 8;
	localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;
	localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;

	// Per-pixel flags
	localparam int FLAG_W        = 2;
	localparam int FLAG_ZERO_BIT = 0;
	localparam int FLAG_FULL_BIT = 1;
	typedef logic [FLAG_W-1:0] flags_t;

	// Item kinds on the input tuser bit
	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	// Config register indexes
	localparam int REG_IDX_W = 2;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_COLS = 2'd0,
		REG_ROWS = 2'd1,
		REG_MODE = 2'd2
	} reg_idx_t;

	// Mode values
	localparam logic MODE_DILATE = 1'b0;
	localparam logic MODE_ERODE  = 1'b1;

	// Which neighbor reads take the pixel being written this cycle
	typedef struct packed {
		logic north;
		logic west;
		logic south;
		logic east;
	} hit_t;

	// Stage-1 payload alongside the window read data
	typedef struct packed {
		logic   last;
		logic   mode;
		hit_t   hit;
		flags_t wflag;
	} s1_ctl_t;

	// Clamp a geometry value to 1..hi
	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	// Zero / full flags of one pixel
	function automatic flags_t pix_flags(input logic [PIX_W-1:0] p);
		flags_t f;
		f = '0;
		f[FLAG_ZERO_BIT] = (p == PIX_ZERO);
		f[FLAG_FULL_BIT] = (p == PIX_FULL);
		return f;
	endfunction

endpackage

FILE: rtl/core/cmf_ram.sv
// Generic RAM: one write port, two registered read ports with shared enable.
module cmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read ports, old data on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

FILE: rtl/core/cross_morphology_filter_unit.sv
// Top level of the cross morphology filter: counters, window store, result stage.
//
// channel | dir | tdata               | tuser / tlast
// --------+-----+---------------------+------------------------------
// s_*     | in  | [7:0] pixel         | tuser: op (0 pixel, 1 flush)
// m_*     | out | [7:0] pixel_out     | tlast: frame_last
// cfg_*   | in  | cfg_data [10:0]     | cfg_index: 0 cols, 1 rows, 2 mode
//
// One request per clock while s_tready is high; the window read register loads on the
// accepting edge, then the output register, where the result shows on m_*.
// Reset clears the counters and loads cols 256, rows 256, mode 0; the window
// memory is not cleared, every entry is written before it is read.
// With m_tready low the output register holds and stage 1 keeps taking
// requests until one with a result is waiting, then s_tready drops.
module cross_morphology_filter_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [cmf_pkg::PIX_W-1:0]   s_tdata,  // [7:0] pixel
	input  logic                        s_tuser,  // [0] op
	// output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [cmf_pkg::PIX_W-1:0]   m_tdata,  // [7:0] pixel_out
	output logic                        m_tlast,
	// config write port
	input  logic                        cfg_wr_en,
	input  logic [cmf_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [cmf_pkg::DIM_W-1:0]   cfg_data
);

	import cmf_pkg::*;

	`include "cross_morphology_filter_unit_defines.svh"

	// config registers
	logic [DIM_W-1:0] cols_q, rows_q, cols_d, rows_d;
	logic             mode_q, mode_d;
	logic [CNT_W-1:0] npix_q;
	logic [2*DIM_W-1:0] npix_prod;

	// frame counters
	logic [CNT_W-1:0] in_cnt_q, out_cnt_q, in_cnt_d, out_cnt_d;

	// accept-side decode
	logic             acc, is_pix, pix_ok, full_in, emit, last, clr_fl;
	logic             wr_en;
	flags_t           wflag;
	logic [CNT_W-1:0] cols_ext, q, q_inc;
	logic [SUM_W-1:0] sum_s, sum_e, n_ext;
	logic [CNT_W-1:0] idx_n, idx_w, idx_s, idx_e;
	hit_t             hit;

	// pipeline
	logic             valid_s1, s1_ready, out_ready;
	s1_ctl_t          ctl_s1;
	flags_t           rd_n, rd_w, rd_s, rd_e;
	flags_t           fl_n, fl_w, fl_s, fl_e, all_fl;
	logic [PIX_W-1:0] res_pix;
	logic             m_valid_q, m_last_q;
	logic [PIX_W-1:0] m_pix_q;

	// config next values, saturated on write
	always_comb begin
		cols_d = cols_q;
		rows_d = rows_q;
		mode_d = mode_q;
		if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_COLS: cols_d = sat_dim(cfg_data, DIM_W'(MAX_COLS));
				REG_ROWS: rows_d = sat_dim(cfg_data, DIM_W'(MAX_ROWS));
				REG_MODE: mode_d = cfg_data[0];
				default:  ;
			endcase
		end
	end

	assign npix_prod = cols_d * rows_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RST;
			rows_q <= ROWS_RST;
			mode_q <= MODE_DILATE;
			npix_q <= NPIX_RST;
		end else begin
			cols_q <= cols_d;
			rows_q <= rows_d;
			mode_q <= mode_d;
			npix_q <= CNT_W'(npix_prod);
		end
	end

	// handshake
	assign out_ready = !m_valid_q || m_tready;
	assign s1_ready  = !valid_s1 || out_ready;
	assign s_tready  = s1_ready;
	assign acc       = s_tvalid && s_tready;

	// request decode
	assign is_pix   = (op_t'(s_tuser) == OP_PIXEL);
	assign cols_ext = CNT_W'(cols_q);
	assign q        = out_cnt_q;
	assign q_inc    = q + CNT_W'(1);
	assign n_ext    = {1'b0, npix_q};
	assign pix_ok   = (in_cnt_q < npix_q);
	assign full_in  = !pix_ok;
	assign wflag    = pix_flags(s_tdata);
	assign wr_en    = acc && is_pix && pix_ok;

	always_comb begin
		emit   = 1'b0;
		clr_fl = 1'b0;
		if (is_pix) begin
			emit = pix_ok && (out_cnt_q < npix_q)
				&& (({1'b0, out_cnt_q} + {1'b0, cols_ext}) <= {1'b0, in_cnt_q});
		end else if (full_in) begin
			emit   = (out_cnt_q < npix_q);
			clr_fl = !(out_cnt_q < npix_q);
		end
	end

	assign last = emit && ({1'b0, q_inc} >= n_ext);

	// counter update
	always_comb begin
		in_cnt_d  = in_cnt_q;
		out_cnt_d = out_cnt_q;
		if (is_pix && pix_ok) begin
			in_cnt_d = in_cnt_q + CNT_W'(1);
		end
		if (emit) begin
			out_cnt_d = q_inc;
		end
		if (last || clr_fl) begin
			in_cnt_d  = '0;
			out_cnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
		end else if (acc) begin
			in_cnt_q  <= in_cnt_d;
			out_cnt_q <= out_cnt_d;
		end
	end

	// neighbor indexes, clamped to 0..N-1
	assign sum_s = {1'b0, q} + {1'b0, cols_ext};
	assign sum_e = {1'b0, q_inc};
	assign idx_n = (q >= cols_ext) ? (q - cols_ext) : '0;
	assign idx_w = (q != '0) ? (q - CNT_W'(1)) : '0;
	assign idx_s = (sum_s >= n_ext) ? (npix_q - CNT_W'(1)) : sum_s[CNT_W-1:0];
	assign idx_e = (sum_e >= n_ext) ? (npix_q - CNT_W'(1)) : sum_e[CNT_W-1:0];

	// reads of the pixel written this cycle take it from the input
	assign hit.north = wr_en && (idx_n == in_cnt_q);
	assign hit.west  = wr_en && (idx_w == in_cnt_q);
	assign hit.south = wr_en && (idx_s == in_cnt_q);
	assign hit.east  = wr_en && (idx_e == in_cnt_q);

	// window store, duplicated for four reads per cycle
	cmf_ram #(
		.WIDTH(FLAG_W),
		.DEPTH(WIN_DEPTH)
	) u_win_nw (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (in_cnt_q[WIN_AW-1:0]),
		.wr_data  (wflag),
		.rd_en    (s1_ready),
		.rd_addr_a(idx_n[WIN_AW-1:0]),
		.rd_addr_b(idx_w[WIN_AW-1:0]),
		.rd_data_a(rd_n),
		.rd_data_b(rd_w)
	);

	cmf_ram #(
		.WIDTH(FLAG_W),
		.DEPTH(WIN_DEPTH)
	) u_win_se (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (in_cnt_q[WIN_AW-1:0]),
		.wr_data  (wflag),
		.rd_en    (s1_ready),
		.rd_addr_a(idx_s[WIN_AW-1:0]),
		.rd_addr_b(idx_e[WIN_AW-1:0]),
		.rd_data_a(rd_s),
		.rd_data_b(rd_e)
	);

	// stage 1: control beside the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready) begin
			ctl_s1.last  <= last;
			ctl_s1.mode  <= mode_q;
			ctl_s1.hit   <= hit;
			ctl_s1.wflag <= wflag;
		end
	end

	// combine the cross
	assign fl_n   = ctl_s1.hit.north ? ctl_s1.wflag : rd_n;
	assign fl_w   = ctl_s1.hit.west  ? ctl_s1.wflag : rd_w;
	assign fl_s   = ctl_s1.hit.south ? ctl_s1.wflag : rd_s;
	assign fl_e   = ctl_s1.hit.east  ? ctl_s1.wflag : rd_e;
	assign all_fl = fl_n & fl_w & fl_s & fl_e;

	always_comb begin
		if (ctl_s1.mode == MODE_ERODE) begin
			res_pix = all_fl[FLAG_FULL_BIT] ? PIX_FULL : PIX_ZERO;
		end else begin
			res_pix = all_fl[FLAG_ZERO_BIT] ? PIX_ZERO : PIX_FULL;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_ready) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s1) begin
			m_pix_q  <= res_pix;
			m_last_q <= ctl_s1.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_pix_q;
	assign m_tlast  = m_last_q;

	// checks
	`CMF_ASSERT_ALWAYS(a_out_behind_in, out_cnt_q <= in_cnt_q, "output count passed input count")
	`CMF_ASSERT_IMPLY(a_out_levels, m_tvalid, (m_tdata == PIX_ZERO) || (m_tdata == PIX_FULL), "result not 0 or 255")
	`CMF_ASSERT_IMPLY(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

FILE: sim/tb_cross_morphology_filter_unit.sv
// Testbench for cross_morphology_filter_unit: directed and random frames vs. a predictor.
module tb_cross_morphology_filter_unit;
	import cmf_pkg::*;

	localparam int STORE_DEPTH  = 2 * MAX_COLS + 2;
	localparam int SETTLE       = 8;
	localparam int DRAIN        = 20;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_ITEMS = 400;

	// Directed table row kinds and how a row's result is judged
	typedef enum logic {
		ROW_CFG  = 1'b0,
		ROW_ITEM = 1'b1
	} row_kind_t;

	typedef enum logic [1:0] {
		CHK_PRED = 2'd0,  // result comes from the predictor
		CHK_NONE = 2'd1,  // no result allowed
		CHK_OUT  = 2'd2   // result typed in the row
	} check_t;

	typedef struct packed {
		row_kind_t        kind;
		reg_idx_t         idx;
		logic [DIM_W-1:0] value;
		op_t              op;
		logic [PIX_W-1:0] pix;
		check_t           chk;
		logic [PIX_W-1:0] exp_pix;
		logic             exp_last;
	} dir_row_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             last;
	} result_t;

	localparam int DIR_ROWS = 31;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// 2x2 frame of zeros, dilate: every result is 0
		'{ROW_CFG,  REG_COLS, 11'd2,    OP_PIXEL, 8'd0,   CHK_NONE, 8'd0,   1'b0},
		'{ROW_CFG,  REG_ROWS, 11'd2,    OP_PIXEL, 8'd0,   CHK_NONE, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd0,   CHK_NONE, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_FLUSH, 8'd0,   CHK_NONE, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd0,   CHK_NONE, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd0,   CHK_OUT,  8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd0,   CHK_OUT,  8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_FLUSH, 8'd0,   CHK_OUT,  8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_FLUSH, 8'd0,   CHK_OUT,  8'd0,   1'b1},
		// flush after frame end is dropped
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_FLUSH, 8'd0,   CHK_NONE, 8'd0,   1'b0},
		// 2x2 frame of full pixels, erode: every result is 255
		'{ROW_CFG,  REG_MODE, 11'd1,    OP_PIXEL, 8'd0,   CHK_NONE, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd255, CHK_NONE, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd255, CHK_NONE, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd255, CHK_OUT,  8'd255, 1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd255, CHK_OUT,  8'd255, 1'b0},
		// pixel past a complete frame is dropped
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd17,  CHK_NONE, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_FLUSH, 8'd0,   CHK_OUT,  8'd255, 1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_FLUSH, 8'd0,   CHK_OUT,  8'd255, 1'b1},
		// mixed levels, erode
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd255, CHK_PRED, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd128, CHK_PRED, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd255, CHK_PRED, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd254, CHK_PRED, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_FLUSH, 8'd0,   CHK_PRED, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_FLUSH, 8'd0,   CHK_PRED, 8'd0,   1'b0},
		// mixed levels, dilate
		'{ROW_CFG,  REG_MODE, 11'd0,    OP_PIXEL, 8'd0,   CHK_NONE, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd1,   CHK_PRED, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd0,   CHK_PRED, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd0,   CHK_PRED, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_PIXEL, 8'd0,   CHK_PRED, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_FLUSH, 8'd0,   CHK_PRED, 8'd0,   1'b0},
		'{ROW_ITEM, REG_COLS, 11'd0,    OP_FLUSH, 8'd0,   CHK_PRED, 8'd0,   1'b0}
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [PIX_W-1:0]     s_tdata   = '0;
	logic                 s_tuser   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [PIX_W-1:0]     m_tdata;
	logic                 m_tlast;
	logic                 cfg_wr_en = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]     cfg_data  = '0;

	// Judgement of the request on the bus, driven alongside its data
	check_t           cur_chk      = CHK_PRED;
	logic [PIX_W-1:0] cur_exp_pix  = '0;
	logic             cur_exp_last = 1'b0;

	// Predictor state: register copies, pixel flags, frame counters
	logic [DIM_W-1:0] set_cols = COLS_RST;
	logic [DIM_W-1:0] set_rows = ROWS_RST;
	logic             set_mode = MODE_DILATE;
	flags_t           flag_store [STORE_DEPTH];
	int unsigned      frame_in  = 0;
	int unsigned      frame_out = 0;

	result_t     due_pixels[$];
	int unsigned fail_count      = 0;
	int unsigned results_checked = 0;
	int unsigned frames_done     = 0;
	int unsigned accepted        = 0;
	int unsigned real_items      = 0;
	int unsigned geometries      = 0;
	int unsigned idle_cycles     = 0;
	int unsigned burst_left      = 0;
	int unsigned holds_asked     = 0;
	int unsigned holds_done      = 0;

	cross_morphology_filter_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Geometry register as the block uses it: clamped to 1..hi
	function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
		if (v == '0) begin
			return 1;
		end
		return (v > hi) ? hi : v;
	endfunction

	// Result for the oldest pending pixel; advances the output counter
	function automatic bit cross_result(input int unsigned cols, n,
			output logic [PIX_W-1:0] res_pix, output logic res_last);
		int unsigned q, nb_n, nb_w, nb_s, nb_e;
		flags_t      common;
		q    = frame_out;
		nb_n = (q >= cols) ? q - cols : 0;
		nb_w = (q >= 1) ? q - 1 : 0;
		nb_s = (q + cols >= n) ? n - 1 : q + cols;
		nb_e = (q + 1 >= n) ? n - 1 : q + 1;
		common = flag_store[nb_n % STORE_DEPTH] & flag_store[nb_w % STORE_DEPTH]
			& flag_store[nb_s % STORE_DEPTH] & flag_store[nb_e % STORE_DEPTH];
		if (set_mode == MODE_ERODE) begin
			res_pix = common[FLAG_FULL_BIT] ? PIX_FULL : PIX_ZERO;
		end else begin
			res_pix = common[FLAG_ZERO_BIT] ? PIX_ZERO : PIX_FULL;
		end
		res_last  = 1'b0;
		frame_out = q + 1;
		if (frame_out >= n) begin
			res_last  = 1'b1;
			frame_in  = 0;
			frame_out = 0;
		end
		return 1'b1;
	endfunction

	// Predicts the result of one accepted request, if it causes one
	function automatic bit cross_filter_predict(input op_t op, input logic [PIX_W-1:0] pix,
			output logic [PIX_W-1:0] res_pix, output logic res_last);
		int unsigned cols, n, p;
		cols     = eff_dim(set_cols, MAX_COLS);
		n        = cols * eff_dim(set_rows, MAX_ROWS);
		res_pix  = '0;
		res_last = 1'b0;
		if (op == OP_PIXEL) begin
			p = frame_in;
			if (p >= n) begin
				return 1'b0;
			end
			flag_store[p % STORE_DEPTH] = {pix == PIX_FULL, pix == PIX_ZERO};
			frame_in = p + 1;
			if (frame_out < n && frame_out + cols <= p) begin
				return cross_result(cols, n, res_pix, res_last);
			end
			return 1'b0;
		end
		if (frame_in < n) begin
			return 1'b0;
		end
		if (frame_out >= n) begin
			frame_in  = 0;
			frame_out = 0;
			return 1'b0;
		end
		return cross_result(cols, n, res_pix, res_last);
	endfunction

	// Result checking, prediction of accepted requests and the watchdog
	always @(posedge clk) begin : scoreboard
		result_t          want;
		bit               got;
		logic [PIX_W-1:0] rp;
		logic             rl;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_checked++;
				if (due_pixels.size() == 0) begin
					fail_count++;
					$error("result with nothing expected: pixel_out %0d frame_last %0b",
						m_tdata, m_tlast);
				end else begin
					want = due_pixels.pop_front();
					if (m_tdata !== want.pix) begin
						fail_count++;
						$error("pixel_out: expected %0d, got %0d", want.pix, m_tdata);
					end
					if (m_tlast !== want.last) begin
						fail_count++;
						$error("frame_last: expected %0b, got %0b", want.last, m_tlast);
					end
					if (want.last) begin
						frames_done++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				accepted++;
				got = cross_filter_predict(op_t'(s_tuser), s_tdata, rp, rl);
				case (cur_chk)
					CHK_PRED: begin
						if (got) begin
							due_pixels.push_back({rp, rl});
						end
					end
					CHK_OUT: begin
						due_pixels.push_back({cur_exp_pix, cur_exp_last});
					end
					default: ;
				endcase
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no handshake for %0d cycles, %0d results outstanding",
					idle_cycles, due_pixels.size());
				$display("tb_cross_morphology_filter_unit failed");
				$finish;
			end
		end
	end

	// Receiver: random stall segments, plus long hold-offs on demand
	initial begin : receiver
		int unsigned style, len, period;
		forever begin
			if (holds_done < holds_asked) begin
				holds_done++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				style  = $urandom_range(0, 3);
				len    = $urandom_range(8, 80);
				period = $urandom_range(2, 5);
				for (int unsigned c = 0; c < len; c++) begin
					case (style)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= ($urandom_range(0, 9) != 0);
						default: m_tready <= (c % period == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Offer one request and wait until it is taken; sender runs in bursts
	task automatic push_item(input op_t op, input logic [PIX_W-1:0] pix,
			input check_t chk = CHK_PRED, input logic [PIX_W-1:0] exp_pix = '0,
			input logic exp_last = 1'b0);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 64);
		end
		burst_left--;
		s_tvalid     <= 1'b1;
		s_tuser      <= op;
		s_tdata      <= pix;
		cur_chk      <= chk;
		cur_exp_pix  <= exp_pix;
		cur_exp_last <= exp_last;
		do @(posedge clk); while (!s_tready);
	endtask

	// Register write once the block has drained
	task automatic write_reg(input reg_idx_t idx, input logic [DIM_W-1:0] val);
		s_tvalid <= 1'b0;
		while (due_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_COLS: set_cols = val;
			REG_ROWS: set_rows = val;
			REG_MODE: set_mode = val[0];
			default: ;
		endcase
	endtask

	// One complete frame with random content and dropped requests mixed in
	task automatic run_frame(input logic [DIM_W-1:0] cols_w, rows_w, input logic mode_w);
		int unsigned      cols, n, zero_pct;
		logic [PIX_W-1:0] pix;
		write_reg(REG_COLS, cols_w);
		write_reg(REG_ROWS, rows_w);
		write_reg(REG_MODE, {{(DIM_W-1){1'b0}}, mode_w});
		cols     = eff_dim(cols_w, MAX_COLS);
		n        = cols * eff_dim(rows_w, MAX_ROWS);
		zero_pct = $urandom_range(0, 100);
		geometries++;
		for (int unsigned i = 0; i < n; i++) begin
			// flush before the frame is complete is dropped
			if ($urandom_range(0, 24) == 0) begin
				push_item(OP_FLUSH, 8'($urandom));
			end
			if ($urandom_range(0, 99) < 12) begin
				pix = 8'($urandom);
			end else begin
				pix = ($urandom_range(0, 99) < zero_pct) ? PIX_ZERO : PIX_FULL;
			end
			push_item(OP_PIXEL, pix);
			real_items++;
		end
		// one flush per pending result, a row's worth in all
		for (int unsigned i = 0; i < cols; i++) begin
			if ($urandom_range(0, 24) == 0) begin
				push_item(OP_PIXEL, 8'($urandom));
			end
			push_item(OP_FLUSH, 8'($urandom));
			real_items++;
		end
	endtask

	initial begin : stimulus
		logic [DIM_W-1:0] cols_w;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rows and mode left at reset values: 1x256 frame
		write_reg(REG_COLS, 11'd1);
		geometries++;
		for (int i = 0; i < 256; i++) begin
			push_item(OP_PIXEL, ($urandom_range(0, 2) == 0) ? 8'($urandom)
				: (($urandom_range(0, 1) == 0) ? PIX_ZERO : PIX_FULL));
		end
		push_item(OP_FLUSH, 8'd0);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIR_TABLE[i].kind == ROW_CFG) begin
				write_reg(DIR_TABLE[i].idx, DIR_TABLE[i].value);
			end else begin
				push_item(DIR_TABLE[i].op, DIR_TABLE[i].pix, DIR_TABLE[i].chk,
					DIR_TABLE[i].exp_pix, DIR_TABLE[i].exp_last);
			end
		end
		geometries++;

		// random small frames; receiver holds off once early on
		holds_asked++;
		while (real_items < RANDOM_ITEMS) begin
			cols_w = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(13, 64))
				: DIM_W'($urandom_range(1, 12));
			run_frame(cols_w, DIM_W'($urandom_range(1, 8)), 1'($urandom_range(0, 1)));
		end

		// tallest frame, out-of-range writes saturate at both ends
		holds_asked++;
		run_frame(11'd0, 11'd2047, MODE_ERODE);

		s_tvalid <= 1'b0;
		while (due_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("%0d frames over %0d geometries in both modes, %0d results checked",
			frames_done, geometries, results_checked);
		$display("%0d requests accepted, dropped pixels and flushes included", accepted);
		if (fail_count == 0) begin
			$display("tb_cross_morphology_filter_unit passed");
		end else begin
			$display("tb_cross_morphology_filter_unit failed");
		end
		$finish;
	end

endmodule
